/* rtl/bcgfp_pkg.sv */
// ----------------------------------------------------------------------------
// bcgfp_pkg
// Shared types, constants and helpers of the bad-CRC gap filler pacer.
// ----------------------------------------------------------------------------
`default_nettype none

package bcgfp_pkg;

    localparam int TAG_W     = 16;
    localparam int GAP_W     = 16;
    localparam int LEN_W     = 11;
    localparam int ACC_W     = 32;
    localparam int TOT_W     = 64;
    localparam int CNT_W     = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [LEN_W-1:0] CHUNK_MAX     = 11'd1538;
    localparam logic [GAP_W-1:0] HALVE_LIMIT   = 16'd2000;
    localparam logic [LEN_W-1:0] WIRE_OVERHEAD = 11'd20;
    localparam logic [LEN_W-1:0] MIN_LOW       = 11'd21;
    localparam logic [LEN_W-1:0] MIN_HIGH      = 11'd1537;
    localparam logic [LEN_W-1:0] MIN_RESET     = 11'd84;
    localparam logic [CNT_W-1:0] MAX_FILLERS   = 6'd43;

    localparam logic REG_MIN_FILLER = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_CHK,
        ST_PKT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic step_add;
        logic commit_fill;
        logic drop_gap;
        logic load_pkt;
    } cmd_t;

    typedef struct packed {
        logic rem_zero;
        logic cap_hit;
        logic below_spent;
        logic slot_free;
    } status_t;

    function automatic logic [LEN_W-1:0] clamp_min(input logic [LEN_W-1:0] value);
        logic [LEN_W-1:0] result;
        result = value;
        if (value < MIN_LOW)
        begin
            result = MIN_LOW;
        end
        else if (value > MIN_HIGH)
        begin
            result = MIN_HIGH;
        end
        return result;
    endfunction

endpackage

`default_nettype wire

/* rtl/bcgfp_regs.sv */
// ----------------------------------------------------------------------------
// bcgfp_regs
// Configuration register file: holds the minimum filler chunk size.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgfp_regs
    import bcgfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic [LEN_W-1:0]      min_filler_bytes
);

    logic [LEN_W-1:0] min_reg;
    logic [LEN_W-1:0] min_next;
    logic             sel_min;

    assign sel_min = (paddr[CFG_ADDR_W-1:2] == REG_MIN_FILLER);

    always_comb
    begin
        min_next = min_reg;
        if (psel && penable && pwrite && sel_min)
        begin
            min_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RESET;
        end
        else
        begin
            min_reg <= min_next;
        end
    end

    assign prdata           = sel_min ? {{(CFG_DATA_W-LEN_W){1'b0}}, min_reg} : '0;
    assign min_filler_bytes = min_reg;

endmodule

`default_nettype wire

/* rtl/bcgfp_ctrl.sv */
// ----------------------------------------------------------------------------
// bcgfp_ctrl
// Sequencer: walks the gap of one word step by step, then releases the packet.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgfp_ctrl
    import bcgfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (status.rem_zero || status.cap_hit)
                begin
                    state_next = ST_PKT;
                end
                else
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                if (status.below_spent)
                begin
                    state_next = ST_PKT;
                end
                else if (status.slot_free)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_PKT:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_ADD:
            begin
                cmd.step_add = !(status.rem_zero || status.cap_hit);
            end
            ST_CHK:
            begin
                cmd.drop_gap    = status.below_spent;
                cmd.commit_fill = !status.below_spent && status.slot_free;
            end
            ST_PKT:
            begin
                cmd.load_pkt = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/bcgfp_dp.sv */
// ----------------------------------------------------------------------------
// bcgfp_dp
// Datapath: byte target and spent accounting, chunk sizing, running totals
// and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgfp_dp
    import bcgfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic [LEN_W-1:0]  min_filler_bytes,
    input  logic [TAG_W-1:0]  packet_tag,
    input  logic [GAP_W-1:0]  gap_bytes,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              is_filler,
    output logic [LEN_W-1:0]  frame_length,
    output logic [TAG_W-1:0]  packet_tag_out,
    output logic              last,
    output logic [TOT_W-1:0]  filler_packets_total,
    output logic [TOT_W-1:0]  filler_bytes_total
);

    logic [TAG_W-1:0] tag_reg;
    logic [GAP_W-1:0] rem_reg;
    logic [GAP_W-1:0] rem_next;
    logic [LEN_W-1:0] minb_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [ACC_W-1:0] sum_reg;
    logic [ACC_W-1:0] target_reg;
    logic [ACC_W-1:0] target_next;
    logic [ACC_W-1:0] spent_reg;
    logic [ACC_W-1:0] spent_next;
    logic [TOT_W-1:0] count_reg;
    logic [TOT_W-1:0] count_next;
    logic [TOT_W-1:0] bytes_reg;
    logic [TOT_W-1:0] bytes_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             is_filler_reg;
    logic [LEN_W-1:0] frame_length_reg;
    logic [TAG_W-1:0] tag_out_reg;
    logic             last_reg;

    logic [GAP_W-1:0] rem_eff;
    logic [LEN_W-1:0] chunk;
    logic [LEN_W-1:0] fill_len;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        rem_eff = (rem_reg < {{(GAP_W-LEN_W){1'b0}}, minb_reg})
                  ? {{(GAP_W-LEN_W){1'b0}}, minb_reg} : rem_reg;
        if (rem_eff < {{(GAP_W-LEN_W){1'b0}}, CHUNK_MAX})
        begin
            chunk = rem_eff[LEN_W-1:0];
        end
        else if (rem_eff > HALVE_LIMIT)
        begin
            chunk = CHUNK_MAX;
        end
        else
        begin
            chunk = rem_eff[LEN_W:1];
        end
        fill_len = chunk - WIRE_OVERHEAD;
    end

    always_comb
    begin
        rem_next       = rem_reg;
        n_next         = n_reg;
        target_next    = target_reg;
        spent_next     = spent_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load_item)
        begin
            rem_next = gap_bytes;
            n_next   = '0;
        end
        if (cmd.drop_gap)
        begin
            target_next = sum_reg;
            rem_next    = '0;
        end
        if (cmd.commit_fill)
        begin
            target_next    = sum_reg - spent_reg;
            spent_next     = {{(ACC_W-LEN_W){1'b0}}, chunk};
            rem_next       = rem_eff - {{(GAP_W-LEN_W){1'b0}}, chunk};
            n_next         = n_reg + CNT_W'(1);
            count_next     = count_reg + TOT_W'(1);
            bytes_next     = bytes_reg + {{(TOT_W-LEN_W){1'b0}}, fill_len};
            out_valid_next = 1'b1;
        end
        if (cmd.load_pkt)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            spent_reg     <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            target_reg    <= target_next;
            spent_reg     <= spent_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            tag_reg  <= packet_tag;
            minb_reg <= clamp_min(min_filler_bytes);
        end
        if (cmd.step_add)
        begin
            sum_reg <= target_reg + {{(ACC_W-GAP_W){1'b0}}, rem_reg};
        end
        if (cmd.commit_fill)
        begin
            is_filler_reg    <= 1'b1;
            frame_length_reg <= fill_len;
            tag_out_reg      <= tag_reg;
            last_reg         <= 1'b0;
        end
        else if (cmd.load_pkt)
        begin
            is_filler_reg    <= 1'b0;
            frame_length_reg <= '0;
            tag_out_reg      <= tag_reg;
            last_reg         <= 1'b1;
        end
    end

    assign status.rem_zero    = (rem_reg == '0);
    assign status.cap_hit     = (n_reg == MAX_FILLERS);
    assign status.below_spent = (sum_reg < spent_reg);
    assign status.slot_free   = slot_free;

    assign out_valid            = out_valid_reg;
    assign is_filler            = is_filler_reg;
    assign frame_length         = frame_length_reg;
    assign packet_tag_out       = tag_out_reg;
    assign last                 = last_reg;
    assign filler_packets_total = count_reg;
    assign filler_bytes_total   = bytes_reg;

`ifndef SYNTHESIS
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit_fill && cmd.load_pkt))
        else $error("filler and packet loaded in the same cycle");

    a_spent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        spent_reg <= {{(ACC_W-LEN_W){1'b0}}, CHUNK_MAX})
        else $error("spent bytes exceed one chunk");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MAX_FILLERS)
        else $error("filler count past cap");

    a_filler_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_filler_reg |-> frame_length_reg != '0 && !last_reg)
        else $error("bad filler word");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_fill |=> count_reg == $past(count_reg) + TOT_W'(1))
        else $error("filler total did not advance");
`endif

endmodule

`default_nettype wire

/* rtl/bad_crc_gap_filler_pacer_unit.sv */
// ----------------------------------------------------------------------------
// bad_crc_gap_filler_pacer_unit
// Paces real packets by emitting bad-CRC filler frames ahead of each one.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: packet tag and wanted gap.
// Output channel (out_valid/out_ready) gives zero to 43 filler words, then the
// packet word with last set. Every word carries the running filler totals.
// The APB port holds min_filler_bytes at address 0 (reset 84).
// Timing: one word is worked at a time. After acceptance each filler passes
// ST_ADD (target add), then ST_CHK (compare/subtract with chunk sizing); a
// final check in ST_ADD or ST_CHK and the packet word in ST_PKT follow, and
// the block accepts again back in ST_IDLE. A filler word is loaded into the
// output register in ST_CHK. The 32-bit target add and compare are split
// over ST_ADD and ST_CHK.
// A single output register parts the sides; a new word is accepted while
// the previous packet word still waits. A stalled receiver holds the block
// in place with no word lost. Reset clears target, spent and both totals.
// ----------------------------------------------------------------------------
`default_nettype none

module bad_crc_gap_filler_pacer_unit
    import bcgfp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TAG_W-1:0]      packet_tag,
    input  logic [GAP_W-1:0]      gap_bytes,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_filler,
    output logic [LEN_W-1:0]      frame_length,
    output logic [TAG_W-1:0]      packet_tag_out,
    output logic                  last,
    output logic [TOT_W-1:0]      filler_packets_total,
    output logic [TOT_W-1:0]      filler_bytes_total
);

    logic [LEN_W-1:0] min_filler_bytes;
    cmd_t             cmd;
    status_t          status;

    assign pready = 1'b1;

    bcgfp_regs u_regs (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .min_filler_bytes (min_filler_bytes)
    );

    bcgfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bcgfp_dp u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .min_filler_bytes     (min_filler_bytes),
        .packet_tag           (packet_tag),
        .gap_bytes            (gap_bytes),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .is_filler            (is_filler),
        .frame_length         (frame_length),
        .packet_tag_out       (packet_tag_out),
        .last                 (last),
        .filler_packets_total (filler_packets_total),
        .filler_bytes_total   (filler_bytes_total)
    );

endmodule

`default_nettype wire

/* sim/tb_bad_crc_gap_filler_pacer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bad_crc_gap_filler_pacer_unit
// Self-checking bench for the bad-CRC gap filler pacer.
// ----------------------------------------------------------------------------
// Packets with a wanted gap go in over a valid/ready channel. A queued driver
// offers them with random pauses. A monitor takes the filler and packet words
// with random stalls and compares each one against words predicted at input
// acceptance from a local copy of target, spent and the running totals.
// The minimum chunk register is rewritten over APB between phases, the clamp
// limits included. One long receiver hold lets the block back up its input.
// ----------------------------------------------------------------------------

module tb_bad_crc_gap_filler_pacer_unit;

    import bcgfp_pkg::*;

    localparam int HOLD_AT       = 185;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int TAIL_CYCLES   = 20;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [GAP_W-1:0] gap;
    } packet_item_t;

    typedef struct {
        logic             is_filler;
        logic [LEN_W-1:0] frame_length;
        logic [TAG_W-1:0] tag;
        logic             last;
        logic [TOT_W-1:0] frame_total;
        logic [TOT_W-1:0] byte_total;
    } frame_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [TAG_W-1:0]      packet_tag = '0;
    logic [GAP_W-1:0]      gap_bytes = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  is_filler;
    logic [LEN_W-1:0]      frame_length;
    logic [TAG_W-1:0]      packet_tag_out;
    logic                  last;
    logic [TOT_W-1:0]      filler_packets_total;
    logic [TOT_W-1:0]      filler_bytes_total;

    packet_item_t pending_packets[$];
    frame_word_t  expected_frames[$];
    packet_item_t next_packet;
    frame_word_t  want;

    logic [ACC_W-1:0] target_acc;
    logic [ACC_W-1:0] spent_acc;
    logic [TOT_W-1:0] filler_cnt;
    logic [TOT_W-1:0] filler_sum;
    logic [LEN_W-1:0] min_filler_cfg;

    int  packets_queued = 0;
    int  packets_taken = 0;
    int  error_count = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    int  hold_cycles = 0;
    int  idle_cycles = 0;
    bit  hold_done = 1'b0;
    bit  send_idle_en = 1'b1;
    bit  recv_idle_en = 1'b1;

    bad_crc_gap_filler_pacer_unit u_dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .packet_tag           (packet_tag),
        .gap_bytes            (gap_bytes),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .is_filler            (is_filler),
        .frame_length         (frame_length),
        .packet_tag_out       (packet_tag_out),
        .last                 (last),
        .filler_packets_total (filler_packets_total),
        .filler_bytes_total   (filler_bytes_total)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int pick_wait(input bit enable);
        int r;
        r = $urandom_range(0, 99);
        if (!enable || r < 55)
        begin
            return 0;
        end
        else if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [GAP_W-1:0] pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return '0;
        end
        else if (r < 45)
        begin
            return GAP_W'($urandom_range(1, 200));
        end
        else if (r < 65)
        begin
            return GAP_W'($urandom_range(200, 1537));
        end
        else if (r < 80)
        begin
            return GAP_W'($urandom_range(1538, 2100));
        end
        else if (r < 92)
        begin
            return GAP_W'($urandom_range(2100, 8000));
        end
        return GAP_W'($urandom_range(0, 65535));
    endfunction

    // Walk the gap in chunks and queue the filler words, then the packet word.
    task automatic predict_pacing(input logic [TAG_W-1:0] tag,
                                  input logic [GAP_W-1:0] gap);
        logic [ACC_W-1:0] remaining;
        logic [ACC_W-1:0] floor_bytes;
        logic [ACC_W-1:0] chunk;
        int               fillers;
        bit               dropped;
        frame_word_t      word;
        remaining   = ACC_W'(gap);
        floor_bytes = ACC_W'(min_filler_cfg);
        if (floor_bytes < ACC_W'(MIN_LOW))
        begin
            floor_bytes = ACC_W'(MIN_LOW);
        end
        if (floor_bytes > ACC_W'(MIN_HIGH))
        begin
            floor_bytes = ACC_W'(MIN_HIGH);
        end
        fillers = 0;
        dropped = 1'b0;
        while (remaining != 0 && !dropped && fillers < int'(MAX_FILLERS))
        begin
            target_acc = target_acc + remaining;
            if (target_acc < spent_acc)
            begin
                dropped = 1'b1;
            end
            else
            begin
                target_acc = target_acc - spent_acc;
                spent_acc  = '0;
                if (remaining < floor_bytes)
                begin
                    remaining = floor_bytes;
                end
                if (remaining < ACC_W'(CHUNK_MAX))
                begin
                    chunk = remaining;
                end
                else if (remaining > ACC_W'(HALVE_LIMIT))
                begin
                    chunk = ACC_W'(CHUNK_MAX);
                end
                else
                begin
                    chunk = remaining >> 1;
                end
                remaining  = remaining - chunk;
                spent_acc  = spent_acc + chunk;
                filler_cnt = filler_cnt + TOT_W'(1);
                filler_sum = filler_sum + TOT_W'(chunk - ACC_W'(WIRE_OVERHEAD));
                word.is_filler    = 1'b1;
                word.frame_length = LEN_W'(chunk - ACC_W'(WIRE_OVERHEAD));
                word.tag          = tag;
                word.last         = 1'b0;
                word.frame_total  = filler_cnt;
                word.byte_total   = filler_sum;
                expected_frames.push_back(word);
                fillers++;
            end
        end
        word.is_filler    = 1'b0;
        word.frame_length = '0;
        word.tag          = tag;
        word.last         = 1'b1;
        word.frame_total  = filler_cnt;
        word.byte_total   = filler_sum;
        expected_frames.push_back(word);
    endtask

    task automatic check_field(input string name, input logic [TOT_W-1:0] exp_val,
                               input logic [TOT_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            packet_tag    <= '0;
            gap_bytes     <= '0;
            send_wait     <= 0;
            packets_taken <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_pacing(packet_tag, gap_bytes);
                packets_taken <= packets_taken + 1;
            end
            if (in_valid && !in_ready)
            begin
                // hold the word until it is taken
            end
            else if (send_wait != 0)
            begin
                in_valid  <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_packets.size() != 0)
            begin
                next_packet = pending_packets.pop_front();
                in_valid    <= 1'b1;
                packet_tag  <= next_packet.tag;
                gap_bytes   <= next_packet.gap;
                send_wait   <= pick_wait(send_idle_en);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("word with no expectation: tag %0d", packet_tag_out);
                    error_count++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("is_filler", TOT_W'(want.is_filler), TOT_W'(is_filler));
                    check_field("frame_length", TOT_W'(want.frame_length),
                                TOT_W'(frame_length));
                    check_field("packet_tag_out", TOT_W'(want.tag),
                                TOT_W'(packet_tag_out));
                    check_field("last", TOT_W'(want.last), TOT_W'(last));
                    check_field("filler_packets_total", want.frame_total,
                                filler_packets_total);
                    check_field("filler_bytes_total", want.byte_total,
                                filler_bytes_total);
                end
            end
            if (hold_cycles != 0)
            begin
                out_ready <= 1'b0;
            end
            else if (recv_wait != 0)
            begin
                out_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                begin
                    recv_wait <= pick_wait(recv_idle_en);
                end
            end
        end
    end

    // Back up the output once so the block stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
        else if (!hold_done && packets_taken == HOLD_AT)
        begin
            hold_cycles <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_packet(input logic [TAG_W-1:0] tag, input logic [GAP_W-1:0] gap);
        packet_item_t item;
        item.tag = tag;
        item.gap = gap;
        pending_packets.push_back(item);
        packets_queued++;
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            push_packet(TAG_W'($urandom_range(0, 65535)), pick_gap());
        end
    endtask

    task automatic drain();
        while (packets_taken != packets_queued || expected_frames.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_min_filler(input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MIN_FILLER, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        min_filler_cfg = value[LEN_W-1:0];
        @(negedge clk);
    endtask

    initial
    begin
        target_acc     = '0;
        spent_acc      = '0;
        filler_cnt     = '0;
        filler_sum     = '0;
        min_filler_cfg = MIN_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_packet(16'h0000, 16'd0);
        push_packet(16'hFFFF, 16'd0);
        push_packet(16'hAAAA, 16'd1);
        push_packet(16'h5555, 16'd1);
        push_packet(16'd1, 16'd83);
        push_packet(16'd2, 16'd84);
        push_packet(16'd3, 16'd1537);
        push_packet(16'd4, 16'd1538);
        push_packet(16'd5, 16'd2000);
        push_packet(16'd6, 16'd2001);
        push_packet(16'd7, 16'hFFFF);
        push_packet(16'd8, 16'h8000);
        push_packet(16'd9, 16'h7FFF);
        push_packet(16'd10, 16'd10);
        push_packet(16'd11, 16'd10);
        push_packet(16'd12, 16'd10);
        drain();

        write_min_filler(32'd0);
        push_packet(16'd13, 16'd1);
        push_packet(16'd14, 16'hFFFF);
        push_random(45);
        drain();

        send_idle_en = 1'b0;
        write_min_filler(32'h0000_07FF);
        push_packet(16'd15, 16'd1);
        push_packet(16'd16, 16'd1600);
        push_packet(16'd17, 16'hFFFF);
        push_random(35);
        drain();

        recv_idle_en = 1'b0;
        write_min_filler(32'd1537);
        push_random(30);
        drain();

        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        write_min_filler(32'd21);
        push_random(40);
        drain();

        write_min_filler(32'($urandom_range(22, 1536)));
        push_random(55);
        drain();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (expected_frames.size() != 0)
        begin
            $error("%0d expected words never arrived", expected_frames.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
